// ===== rtl/free_row_gap_finder_assert.svh =====
// Assertion macros for the free row gap finder RTL.
// No dependencies; the checks are left out when SYNTHESIS is set.
`ifndef FREE_ROW_GAP_FINDER_ASSERT_SVH
`define FREE_ROW_GAP_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define FRGF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRGF_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRGF_ASSERT(label, clk, rst, prop, msg)
`define FRGF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/frgf_pkg.sv =====
// Shared types and constants of the free row gap finder.
// No dependencies.
package frgf_pkg;
   localparam int MAX_SPANS_DEF = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP_WIDTH  = 2'd3;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] span_top;
      logic [15:0] span_rows;
   } req_type;

   typedef struct packed {
      logic [15:0] gap_top;
      logic [15:0] gap_bottom;
      logic        gap_valid;
      logic        last_gap;
      logic        spans_dropped;
   } rsp_type;
endpackage

// ===== rtl/frgf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module frgf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== rtl/free_row_gap_finder.sv =====
// Free row gap finder top level: span store, sorted walk, merge and gap output.
// Depends on frgf_pkg, frgf_ram and free_row_gap_finder_assert.svh.
// Loads may arrive back to back. A finish walks the span store in sorted order by
// repeated scans of the store memory, one entry read per cycle; a stall on the result
// side holds the walk up. Spans beyond MAX_SPANS are dropped and flagged on every
// result of the next finish. Identical spans are visited once, which does not change
// the merged result.
`include "free_row_gap_finder_assert.svh"
module free_row_gap_finder
   import frgf_pkg::*;
#(
   parameter int MAX_SPANS = MAX_SPANS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);
   localparam int CNT_W = $clog2(MAX_SPANS + 1);
   localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPANS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_TAIL  = 3'd4;
   localparam logic [2:0] ST_OFFER = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]       state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic             ovf_ff, ovf_in, drop_ff, drop_in;
   logic [15:0]      height_ff, height_in, width_ff, width_in;
   logic [15:0]      minh_ff, minh_in, minw_ff, minw_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rd_v_ff, rd_v_in, found_ff, found_in, have_last_ff, have_last_in;
   logic             have_cur_ff, have_cur_in, held_v_ff, held_v_in;
   logic [31:0]      best_ff, best_in, last_ff, last_in;
   logic [15:0]      cur_s_ff, cur_s_in, cur_e_ff, cur_e_in;
   logic [16:0]      top_ff, top_in;
   logic [15:0]      held_top_ff, held_top_in, held_bot_ff, held_bot_in;
   logic [15:0]      cand_top_ff, cand_top_in, cand_bot_ff, cand_bot_in;

   logic             load_acc, fin_acc, wr_en, rd_en, slot_free, better, gap_ok, tail_ok;
   logic [15:0]      minh_eff, rows_eff, end_sat, s_best, e_best, hm1;
   logic [16:0]      end_sum, gap_diff;
   logic [31:0]      rd_data;

   frgf_ram #(.WIDTH(32), .DEPTH(MAX_SPANS)) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (cnt_ff[AW-1:0]),
      .wr_data    ({req_data.span_top, end_sat}),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign load_acc  = req_valid && !req_stall && (req_data.opcode == OP_LOAD);
   assign fin_acc   = req_valid && !req_stall && (req_data.opcode == OP_FINISH);
   assign rows_eff  = (req_data.span_rows == 16'd0) ? 16'd1 : req_data.span_rows;
   assign end_sum   = {1'b0, req_data.span_top} + {1'b0, rows_eff} - 17'd1;
   assign end_sat   = end_sum[16] ? 16'hFFFF : end_sum[15:0];
   assign wr_en     = load_acc && (cnt_ff < MAX_CNT);
   assign rd_en     = (state_ff == ST_SCAN) && (idx_ff < cnt_ff);
   assign minh_eff  = (minh_ff == 16'd0) ? 16'd1 : minh_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign s_best    = best_ff[31:16];
   assign e_best    = best_ff[15:0];
   assign hm1       = height_ff - 16'd1;
   assign better    = (!have_last_ff || rd_data > last_ff) && (!found_ff || rd_data < best_ff);
   assign gap_diff  = {1'b0, cur_s_ff} - top_ff;
   assign gap_ok    = ({1'b0, cur_s_ff} >= top_ff) && (gap_diff >= {1'b0, minh_eff});
   assign tail_ok   = (top_ff < {1'b0, hm1})
                      && (({1'b0, height_ff} - top_ff) >= {1'b0, minh_eff});

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      drop_in      = drop_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      minh_in      = minh_ff;
      minw_in      = minw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_v_in      = 1'b0;
      found_in     = found_ff;
      have_last_in = have_last_ff;
      have_cur_in  = have_cur_ff;
      held_v_in    = held_v_ff;
      best_in      = best_ff;
      last_in      = last_ff;
      cur_s_in     = cur_s_ff;
      cur_e_in     = cur_e_ff;
      top_in       = top_ff;
      held_top_in  = held_top_ff;
      held_bot_in  = held_bot_ff;
      cand_top_in  = cand_top_ff;
      cand_bot_in  = cand_bot_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_HEIGHT:   height_in = csr_data;
            CSR_IMAGE_WIDTH:    width_in  = csr_data;
            CSR_MIN_GAP_HEIGHT: minh_in   = csr_data;
            CSR_MIN_GAP_WIDTH:  minw_in   = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (load_acc) begin
               if (cnt_ff < MAX_CNT) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (fin_acc) begin
               drop_in      = ovf_ff;
               held_v_in    = 1'b0;
               have_cur_in  = 1'b0;
               have_last_in = 1'b0;
               found_in     = 1'b0;
               idx_in       = '0;
               top_in       = '0;
               if (width_ff < minw_ff || height_ff < minh_eff) begin
                  state_in = ST_FIN;
               end else if (cnt_ff == '0) begin
                  held_v_in   = 1'b1;
                  held_top_in = 16'd0;
                  held_bot_in = hm1;
                  state_in    = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               idx_in  = idx_ff + CNT_W'(1);
               rd_v_in = 1'b1;
            end
            if (rd_v_ff && better) begin
               best_in  = rd_data;
               found_in = 1'b1;
            end
            if (!rd_en && !rd_v_ff) begin
               state_in = found_ff ? ST_STEP : ST_FLUSH;
            end
         end
         ST_STEP: begin
            last_in      = best_ff;
            have_last_in = 1'b1;
            found_in     = 1'b0;
            idx_in       = '0;
            state_in     = ST_SCAN;
            if (!have_cur_ff) begin
               have_cur_in = 1'b1;
               cur_s_in    = s_best;
               cur_e_in    = e_best;
            end else if ({1'b0, cur_e_ff} + 17'd1 < {1'b0, s_best}) begin
               top_in      = {1'b0, cur_e_ff} + 17'd1;
               cur_s_in    = s_best;
               cur_e_in    = e_best;
               cand_top_in = top_ff[15:0];
               cand_bot_in = cur_s_ff - 16'd1;
               if (gap_ok) begin
                  ret_in   = ST_SCAN;
                  state_in = ST_OFFER;
               end
            end else if (e_best > cur_e_ff) begin
               cur_e_in = e_best;
            end
         end
         ST_FLUSH: begin
            top_in      = {1'b0, cur_e_ff} + 17'd1;
            cand_top_in = top_ff[15:0];
            cand_bot_in = cur_s_ff - 16'd1;
            ret_in      = ST_TAIL;
            state_in    = gap_ok ? ST_OFFER : ST_TAIL;
         end
         ST_TAIL: begin
            cand_top_in = top_ff[15:0];
            cand_bot_in = hm1;
            ret_in      = ST_FIN;
            state_in    = tail_ok ? ST_OFFER : ST_FIN;
         end
         ST_OFFER: begin
            if (!held_v_ff) begin
               held_v_in   = 1'b1;
               held_top_in = cand_top_ff;
               held_bot_in = cand_bot_ff;
               state_in    = ret_ff;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{gap_top: held_top_ff, gap_bottom: held_bot_ff,
                                gap_valid: 1'b1, last_gap: 1'b0,
                                spans_dropped: drop_ff};
               held_top_in  = cand_top_ff;
               held_bot_in  = cand_bot_ff;
               state_in     = ret_ff;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{gap_top: held_v_ff ? held_top_ff : 16'd0,
                                gap_bottom: held_v_ff ? held_bot_ff : 16'd0,
                                gap_valid: held_v_ff, last_gap: 1'b1,
                                spans_dropped: drop_ff};
               cnt_in       = '0;
               ovf_in       = 1'b0;
               held_v_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         height_ff    <= 16'd0;
         width_ff     <= 16'd0;
         minh_ff      <= 16'd1;
         minw_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         have_last_ff <= 1'b0;
         have_cur_ff  <= 1'b0;
         held_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         minh_ff      <= minh_in;
         minw_ff      <= minw_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_v_in;
         found_ff     <= found_in;
         have_last_ff <= have_last_in;
         have_cur_ff  <= have_cur_in;
         held_v_ff    <= held_v_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
      best_ff     <= best_in;
      last_ff     <= last_in;
      cur_s_ff    <= cur_s_in;
      cur_e_ff    <= cur_e_in;
      top_ff      <= top_in;
      held_top_ff <= held_top_in;
      held_bot_ff <= held_bot_in;
      cand_top_ff <= cand_top_in;
      cand_bot_ff <= cand_bot_in;
   end

   `FRGF_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= MAX_CNT, "span count above capacity")
   `FRGF_ASSERT(a_fin_leaves_idle, clock, reset, fin_acc |=> state_ff != ST_IDLE, "finish ignored")
   `FRGF_ASSERT(a_invalid_zero, clock, reset,
      (rsp_valid_ff && !rsp_data_ff.gap_valid) |-> (rsp_data_ff.last_gap
      && rsp_data_ff.gap_top == 16'd0 && rsp_data_ff.gap_bottom == 16'd0),
      "invalid result not final or not zero")
   `FRGF_ASSERT(a_fin_clears, clock, reset,
      (state_ff == ST_FIN && slot_free) |=> (cnt_ff == '0 && !ovf_ff),
      "store not cleared after finish")
endmodule

// ===== dv/free_row_gap_finder_test.sv =====
// Self-checking testbench for free_row_gap_finder: loads object spans, finishes
// images and checks every emitted gap against an in-bench gap predictor.
// Depends on frgf_pkg and the free_row_gap_finder RTL.
module free_row_gap_finder_test;
   import frgf_pkg::*;

   localparam int SPAN_CAP   = MAX_SPANS_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 40;
   localparam int RAND_ITEMS = 130;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_HEIGHT;
   logic [15:0] csr_data = '0;

   free_row_gap_finder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type pending_items[$];
   rsp_type expected_gaps[$];
   int      fail_count = 0;
   bit      quiet = 1'b0;
   bit      hold_request = 1'b0;
   bit      req_took = 1'b0;

   // gap predictor state
   logic [15:0] cfg_height = 16'd0;
   logic [15:0] cfg_width = 16'd0;
   logic [15:0] cfg_min_h = 16'd1;
   logic [15:0] cfg_min_w = 16'd0;
   logic [15:0] start_mem[SPAN_CAP];
   logic [15:0] end_mem[SPAN_CAP];
   int unsigned stored_spans = 0;
   bit          dropped_flag = 1'b0;

   function automatic void push_gap(int unsigned top, int unsigned bot, bit ok);
      rsp_type r;
      r.gap_top       = top[15:0];
      r.gap_bottom    = bot[15:0];
      r.gap_valid     = ok;
      r.last_gap      = 1'b0;
      r.spans_dropped = dropped_flag;
      expected_gaps = {expected_gaps, r};
   endfunction

   function automatic void predict_finish();
      int unsigned st[SPAN_CAP];
      int unsigned en[SPAN_CAP];
      int unsigned n, minh, cs, ce, top, s, e, j, h;
      int emitted;
      n = stored_spans;
      h = cfg_height;
      minh = (cfg_min_h == 16'd0) ? 1 : cfg_min_h;
      emitted = 0;
      top = 0;
      if (cfg_width < cfg_min_w || h < minh) begin
         push_gap(0, 0, 1'b0);
         emitted++;
      end else if (n == 0) begin
         push_gap(0, h - 1, 1'b1);
         emitted++;
      end else begin
         for (int i = 0; i < n; i++) begin
            s = start_mem[i];
            e = end_mem[i];
            j = i;
            while (j > 0 && (s < st[j-1] || (s == st[j-1] && e < en[j-1]))) begin
               st[j] = st[j-1];
               en[j] = en[j-1];
               j--;
            end
            st[j] = s;
            en[j] = e;
         end
         cs = st[0];
         ce = en[0];
         for (int i = 1; i <= n; i++) begin
            if (i < n && !(ce + 1 < st[i])) begin
               if (en[i] > ce) ce = en[i];
            end else begin
               if (cs >= top && cs - top >= minh) begin
                  push_gap(top, cs - 1, 1'b1);
                  emitted++;
               end
               top = ce + 1;
               if (i < n) begin
                  cs = st[i];
                  ce = en[i];
               end
            end
         end
         if (top < h - 1 && h - top >= minh) begin
            push_gap(top, h - 1, 1'b1);
            emitted++;
         end
         if (emitted == 0) push_gap(0, 0, 1'b0);
      end
      expected_gaps[$].last_gap = 1'b1;
      stored_spans = 0;
      dropped_flag = 1'b0;
   endfunction

   function automatic void predict_load(req_type it);
      int unsigned rows, last;
      rows = (it.span_rows == 16'd0) ? 1 : it.span_rows;
      if (stored_spans < SPAN_CAP) begin
         last = it.span_top + rows - 1;
         if (last > 32'hFFFF) last = 32'hFFFF;
         start_mem[stored_spans] = it.span_top;
         end_mem[stored_spans] = last[15:0];
         stored_spans++;
      end else begin
         dropped_flag = 1'b1;
      end
   endfunction

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin
      rsp_type want;
      req_took <= req_valid && !req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_HEIGHT:   cfg_height = csr_data;
               CSR_IMAGE_WIDTH:    cfg_width = csr_data;
               CSR_MIN_GAP_HEIGHT: cfg_min_h = csr_data;
               CSR_MIN_GAP_WIDTH:  cfg_min_w = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_data.opcode == OP_FINISH) predict_finish();
            else predict_load(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_gaps.size() == 0) begin
               $error("unexpected result transaction top=%0d bottom=%0d",
                  rsp_data.gap_top, rsp_data.gap_bottom);
               fail_count++;
            end else begin
               want = expected_gaps.pop_front();
               if (rsp_data.gap_top !== want.gap_top) begin
                  $error("gap_top exp %0d got %0d", want.gap_top, rsp_data.gap_top);
                  fail_count++;
               end
               if (rsp_data.gap_bottom !== want.gap_bottom) begin
                  $error("gap_bottom exp %0d got %0d", want.gap_bottom,
                     rsp_data.gap_bottom);
                  fail_count++;
               end
               if (rsp_data.gap_valid !== want.gap_valid) begin
                  $error("gap_valid exp %0d got %0d", want.gap_valid,
                     rsp_data.gap_valid);
                  fail_count++;
               end
               if (rsp_data.last_gap !== want.last_gap) begin
                  $error("last_gap exp %0d got %0d", want.last_gap, rsp_data.last_gap);
                  fail_count++;
               end
               if (rsp_data.spans_dropped !== want.spans_dropped) begin
                  $error("spans_dropped exp %0d got %0d", want.spans_dropped,
                     rsp_data.spans_dropped);
                  fail_count++;
               end
            end
         end
      end
   end

   // request driver
   int send_idle = 0;
   always @(negedge clock) begin
      logic    nxt_valid;
      req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (!reset && (!req_valid || req_took)) begin
         nxt_valid = 1'b0;
         if (send_idle > 0) begin
            send_idle--;
         end else if (pending_items.size() != 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               send_idle = $urandom_range(1, 13) - 1;
            end else begin
               nxt_data = pending_items.pop_front();
               nxt_valid = 1'b1;
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // result receiver
   int recv_idle = 0;
   always @(negedge clock) begin
      logic nxt_stall;
      nxt_stall = 1'b0;
      if (hold_request) begin
         hold_request = 1'b0;
         recv_idle = 400;
      end
      if (recv_idle > 0) begin
         recv_idle--;
         nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         recv_idle = $urandom_range(1, 13) - 1;
         nxt_stall = 1'b1;
      end
      rsp_stall <= nxt_stall;
   end

   // watchdog on transaction progress
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("free_row_gap_finder: mismatch");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_image(logic [15:0] h, logic [15:0] w, logic [15:0] mh,
                            logic [15:0] mw);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_MIN_GAP_HEIGHT, mh);
      write_csr(CSR_MIN_GAP_WIDTH, mw);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_gaps.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void add_span(int unsigned top, int unsigned rows);
      req_type it;
      it.opcode = OP_LOAD;
      it.span_top = top[15:0];
      it.span_rows = rows[15:0];
      pending_items = {pending_items, it};
   endfunction

   function automatic void add_finish();
      req_type it;
      it.opcode = OP_FINISH;
      it.span_top = $urandom();
      it.span_rows = $urandom();
      pending_items = {pending_items, it};
   endfunction

   function automatic int gen_image(int unsigned h);
      int unsigned n, top, rows, r;
      r = $urandom_range(0, 9);
      n = (r == 0) ? $urandom_range(33, 36) : (r < 3) ? 0 : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         top = (r == 0) ? $urandom_range(0, 65535) : $urandom_range(0, h + 20);
         if (top > 65535) top = 65535;
         r = $urandom_range(0, 11);
         rows = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 65535) :
            $urandom_range(1, 30);
         add_span(top, rows);
      end
      add_finish();
      return n + 1;
   endfunction

   initial begin
      int sent;
      int unsigned h, w, mh, mw, r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero-height image is too small
      add_span(5, 3);
      add_finish();
      drain();

      set_image(100, 50, 5, 10);
      add_span(10, 5);      // overlap, adjacency, duplicate
      add_span(12, 10);
      add_span(22, 4);
      add_span(10, 5);
      add_span(40, 0);      // zero row count
      add_span(0, 3);
      add_span(120, 7);     // beyond the image
      add_span(65535, 65535);
      add_finish();
      add_finish();         // no objects
      drain();

      set_image(65535, 9, 0, 10);   // too narrow, zero min height
      add_span(3, 1);
      add_finish();
      drain();

      set_image(65535, 65535, 65535, 65535);
      add_finish();
      add_span(0, 65535);
      add_finish();         // no qualifying gap
      drain();

      set_image(300, 65535, 1, 0);
      for (int i = 0; i < SPAN_CAP + 2; i++) add_span(i * 8, $urandom_range(1, 8));
      add_finish();         // store overflow
      drain();

      // back pressure: receiver holds off while loads keep coming
      hold_request = 1'b1;
      for (int k = 0; k < 3; k++) void'(gen_image(300));
      drain();

      sent = 0;
      while (sent < RAND_ITEMS) begin
         if (sent > RAND_ITEMS * 4 / 5) quiet = 1'b1;
         r = $urandom_range(0, 9);
         h = (r == 0) ? $urandom_range(0, 65535) : (r == 1) ? 0 :
            $urandom_range(20, 400);
         r = $urandom_range(0, 9);
         mh = (r == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 8);
         w = $urandom_range(0, 65535);
         mw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) :
            $urandom_range(0, w);
         set_image(h[15:0], w[15:0], mh[15:0], mw[15:0]);
         sent += gen_image(h);
         drain();
      end

      if (fail_count == 0) begin
         $display("free_row_gap_finder: match");
      end else begin
         $display("free_row_gap_finder: mismatch");
      end
      $finish;
   end
endmodule
